@@ sv/rgbpnp_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbpnp_pkg
// Shared types, palette tables and frame constants for the palette packer.
// ----------------------------------------------------------------------------
package rgbpnp_pkg;

	localparam int FRAME_WIDTH  = 1200;
	localparam int FRAME_HEIGHT = 1600;
	localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int POS_W        = $clog2(FRAME_PIXELS + 1);
	localparam int IDX_W        = 20;
	localparam int NUM_COLOURS  = 6;
	localparam int DIST_W       = 18;

	typedef logic [3:0] code_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		code_t      code;
	} pal_entry_t;

	localparam pal_entry_t IDEAL_PAL [NUM_COLOURS] = '{
		'{r: 8'd0,   g: 8'd0,   b: 8'd0,   code: 4'h0},
		'{r: 8'd255, g: 8'd255, b: 8'd255, code: 4'h1},
		'{r: 8'd255, g: 8'd255, b: 8'd0,   code: 4'h2},
		'{r: 8'd255, g: 8'd0,   b: 8'd0,   code: 4'h3},
		'{r: 8'd0,   g: 8'd0,   b: 8'd255, code: 4'h5},
		'{r: 8'd0,   g: 8'd255, b: 8'd0,   code: 4'h6}
	};

	localparam pal_entry_t MEASURED_PAL [NUM_COLOURS] = '{
		'{r: 8'd2,   g: 8'd2,   b: 8'd2,   code: 4'h0},
		'{r: 8'd190, g: 8'd200, b: 8'd200, code: 4'h1},
		'{r: 8'd205, g: 8'd202, b: 8'd0,   code: 4'h2},
		'{r: 8'd135, g: 8'd19,  b: 8'd0,   code: 4'h3},
		'{r: 8'd5,   g: 8'd64,  b: 8'd158, code: 4'h5},
		'{r: 8'd39,  g: 8'd102, b: 8'd60,  code: 4'h6}
	};

	localparam code_t DEFAULT_CODE = 4'h1;

	function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return {8'h00, d} * {8'h00, d};
	endfunction

endpackage

@@ sv/rgbpnp_quant.sv @@
// ----------------------------------------------------------------------------
// rgbpnp_quant
// Maps one pixel to a panel colour code: exact ideal match, else nearest
// measured colour by squared distance, first entry winning ties.
// ----------------------------------------------------------------------------
module rgbpnp_quant (
	input  logic [7:0]           r,
	input  logic [7:0]           g,
	input  logic [7:0]           b,
	output rgbpnp_pkg::code_t    code
);

	logic [rgbpnp_pkg::DIST_W-1:0] sq_dist [rgbpnp_pkg::NUM_COLOURS];

	always_comb begin
		for (int i = 0; i < rgbpnp_pkg::NUM_COLOURS; i++) begin
			sq_dist[i] = rgbpnp_pkg::DIST_W'(rgbpnp_pkg::sq_diff(r, rgbpnp_pkg::MEASURED_PAL[i].r))
				+ rgbpnp_pkg::DIST_W'(rgbpnp_pkg::sq_diff(g, rgbpnp_pkg::MEASURED_PAL[i].g))
				+ rgbpnp_pkg::DIST_W'(rgbpnp_pkg::sq_diff(b, rgbpnp_pkg::MEASURED_PAL[i].b));
		end
	end

	always_comb begin
		logic                          match;
		rgbpnp_pkg::code_t             match_code;
		logic [rgbpnp_pkg::DIST_W-1:0] best_dist;
		rgbpnp_pkg::code_t             best_code;
		match      = 1'b0;
		match_code = rgbpnp_pkg::DEFAULT_CODE;
		// walk down so the lowest matching entry wins
		for (int i = rgbpnp_pkg::NUM_COLOURS - 1; i >= 0; i--) begin
			if (r == rgbpnp_pkg::IDEAL_PAL[i].r && g == rgbpnp_pkg::IDEAL_PAL[i].g &&
				b == rgbpnp_pkg::IDEAL_PAL[i].b) begin
				match      = 1'b1;
				match_code = rgbpnp_pkg::IDEAL_PAL[i].code;
			end
		end
		// all-ones exceeds any real distance, so entry zero always seeds the search
		best_dist = '1;
		best_code = rgbpnp_pkg::DEFAULT_CODE;
		for (int i = 0; i < rgbpnp_pkg::NUM_COLOURS; i++) begin
			if (sq_dist[i] < best_dist) begin
				best_dist = sq_dist[i];
				best_code = rgbpnp_pkg::MEASURED_PAL[i].code;
			end
		end
		code = match ? match_code : best_code;
	end

endmodule

@@ sv/rgb_to_palette_nibble_packer.sv @@
// ----------------------------------------------------------------------------
// rgb_to_palette_nibble_packer
// Quantizes 24-bit pixels to 4-bit panel codes and packs two codes per byte.
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir | handshake
//  --------+------------------------------------------+-----+-------------------
//  pixel   | red, green, blue, frame_end              | in  | in_valid / in_stall
//  byte    | packed_byte, byte_index, frame_done      | out | out_valid / out_stall
//  config  | cfg_write, cfg_data (swap_red_blue)      | in  | write enable only
//
//  one pixel per cycle while out_stall is low; a pixel lands in the input
//  register when it is accepted, and any byte it emits lands in the result
//  register once that is free; the quantizer and packing logic sit between
//  the two registers; arst_n clears valids, the pending nibble, the pixel
//  counter and the swap bit; out_stall holds the result register and backs up into in_stall
// ----------------------------------------------------------------------------
module rgb_to_palette_nibble_packer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic                        cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	input  logic                        frame_end,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  packed_byte,
	output logic [rgbpnp_pkg::IDX_W-1:0] byte_index,
	output logic                        frame_done
);

	localparam logic [rgbpnp_pkg::POS_W-1:0] FRAME_PIXELS_C =
		rgbpnp_pkg::POS_W'(rgbpnp_pkg::FRAME_PIXELS);

	logic                          swap_q;
	logic                          valid_s1;
	logic [7:0]                    red_s1;
	logic [7:0]                    green_s1;
	logic [7:0]                    blue_s1;
	logic                          last_s1;
	logic [rgbpnp_pkg::POS_W-1:0]  pos_q;
	rgbpnp_pkg::code_t             pend_q;

	logic                          out_free;
	logic                          advance;
	logic [7:0]                    qr;
	logic [7:0]                    qb;
	rgbpnp_pkg::code_t             code;

	logic                          emit;
	logic [7:0]                    byte_d;
	logic                          done_d;
	logic [rgbpnp_pkg::POS_W-1:0]  pos_d;
	rgbpnp_pkg::code_t             pend_d;

	assign out_free = !out_valid || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	assign qr = swap_q ? blue_s1 : red_s1;
	assign qb = swap_q ? red_s1 : blue_s1;

	rgbpnp_quant u_quant (
		.r    (qr),
		.g    (green_s1),
		.b    (qb),
		.code (code)
	);

	always_comb begin
		emit   = 1'b0;
		byte_d = {code, 4'h0};
		done_d = 1'b1;
		pos_d  = pos_q;
		pend_d = pend_q;
		if (pos_q >= FRAME_PIXELS_C) begin
			// frame full: drop pixels, a frame end still restarts the frame
			if (last_s1) begin
				emit   = pos_q[0];
				byte_d = {pend_q, 4'h0};
				pos_d  = '0;
				pend_d = '0;
			end
		end else if (!pos_q[0]) begin
			if (last_s1) begin
				emit   = 1'b1;
				pos_d  = '0;
				pend_d = '0;
			end else begin
				pend_d = code;
				pos_d  = pos_q + 1'b1;
			end
		end else begin
			emit   = 1'b1;
			byte_d = {pend_q, code};
			done_d = last_s1;
			if (last_s1) begin
				pos_d  = '0;
				pend_d = '0;
			end else begin
				pos_d  = pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b0;
		end else if (cfg_write) begin
			swap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			last_s1  <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			pend_q <= '0;
		end else if (advance) begin
			pos_q  <= pos_d;
			pend_q <= pend_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= emit;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			packed_byte <= byte_d;
			byte_index  <= rgbpnp_pkg::IDX_W'(pos_q >> 1);
			frame_done  <= done_d;
		end
	end

endmodule

@@ sv/rgbpnp_check.sv @@
// ----------------------------------------------------------------------------
// rgbpnp_check
// Port-level checks for the palette packer, bound onto the top level.
// ----------------------------------------------------------------------------
module rgbpnp_check (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_stall,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [7:0]                   packed_byte,
	input  logic [rgbpnp_pkg::IDX_W-1:0] byte_index,
	input  logic                         frame_done
);

	// a held transaction keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(packed_byte) &&
			$stable(byte_index) && $stable(frame_done))
		else $error("output transaction changed while stalled");

	// input backpressure only comes from a stalled, full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall raised without output backpressure");

	a_high_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> packed_byte[7:4] != 4'd4 && packed_byte[7:4] <= 4'd6)
		else $error("illegal colour code in high nibble");

	// low nibble is a legal code, and zero on a flushed half byte is included
	a_low_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> packed_byte[3:0] != 4'd4 && packed_byte[3:0] <= 4'd6)
		else $error("illegal colour code in low nibble");

endmodule

bind rgb_to_palette_nibble_packer rgbpnp_check u_rgbpnp_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.packed_byte (packed_byte),
	.byte_index  (byte_index),
	.frame_done  (frame_done)
);
